// ===== design/spjq_pkg.sv =====
// Types and codes shared by the sorted job queue modules.
`default_nettype none
package spjq_pkg;

	// Operation codes carried on func.
	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int unsigned CAP_W   = 5;
	localparam int unsigned COUNT_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic        [15:0] id;
		logic        [15:0] size;
		logic        [7:0]  owner;
		logic signed [15:0] rank;
	} job_t;

	// Broadcast from the queue control to every cell.
	typedef struct packed {
		logic ins;
		logic rem;
		job_t job;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/sorted_priority_job_queue.sv =====
// Top level of the sorted job priority queue: a row of compare-and-shift slots.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | func, job_id, job_size, job_owner, job_rank
//  out      | out_valid / out_ready  | status, out_id, out_size, out_owner, out_rank, count
//  cfg      | cfg_valid / cfg_ready  | cfg_data (capacity)
//
// Every operation's result beat is registered and appears the cycle after the input beat;
// a new input beat is taken each cycle unless a result beat is held. The cycle time is set
// by the rank compare broadcast to all DEPTH slots and the shift select in each slot.
// Reset empties the queue and sets capacity to 16; slot contents are not cleared.
// in_ready drops only while a result beat is held and out_ready is low.
`default_nettype none
module sorted_priority_job_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               func,
	input  wire        [15:0] job_id,
	input  wire        [15:0] job_size,
	input  wire        [7:0]  job_owner,
	input  wire signed [15:0] job_rank,
	output logic              out_valid,
	input  wire               out_ready,
	output logic       [1:0]  status,
	output logic       [15:0] out_id,
	output logic       [15:0] out_size,
	output logic       [7:0]  out_owner,
	output logic signed [15:0] out_rank,
	output logic       [4:0]  count,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire        [4:0]  cfg_data
);

	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > spjq_pkg::CAP_W) ? CW : spjq_pkg::CAP_W;

	logic [spjq_pkg::CAP_W-1:0] capacity_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_next;
	logic                       out_valid_q;
	logic [1:0]                 status_q;
	spjq_pkg::job_t             out_job_q;
	logic [spjq_pkg::COUNT_W-1:0] out_count_q;

	logic [CMPW-1:0]            cnt_w;
	logic [CMPW-1:0]            cnt_next_w;
	logic                       accept;
	logic                       full;
	logic                       empty;
	logic                       do_ins;
	logic                       do_rem;
	logic [1:0]                 status_next;
	spjq_pkg::cell_ctl_t        ctl;

	logic [DEPTH-1:0]           keep;
	logic [DEPTH-1:0]           occupied;
	spjq_pkg::job_t             cell_job [DEPTH];

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	assign cnt_w = CMPW'(count_q);
	assign full  = (cnt_w >= CMPW'(capacity_q)) || (cnt_w >= CMPW'(DEPTH));
	assign empty = (count_q == '0);

	assign do_ins = accept && (func == spjq_pkg::FN_INSERT) && !full;
	assign do_rem = accept && (func == spjq_pkg::FN_REMOVE) && !empty;

	always_comb begin
		count_next  = count_q;
		status_next = spjq_pkg::ST_DONE;
		if (do_ins) begin
			count_next = count_q + 1'b1;
		end else if (do_rem) begin
			count_next = count_q - 1'b1;
		end
		if (func == spjq_pkg::FN_INSERT) begin
			if (full) status_next = spjq_pkg::ST_FULL;
		end else begin
			if (empty) status_next = spjq_pkg::ST_EMPTY;
		end
	end

	assign cnt_next_w = CMPW'(count_next);

	always_comb begin
		ctl.ins       = do_ins;
		ctl.rem       = do_rem;
		ctl.job.id    = job_id;
		ctl.job.size  = job_size;
		ctl.job.owner = job_owner;
		ctl.job.rank  = job_rank;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		spjq_pkg::job_t left_job;
		spjq_pkg::job_t right_job;
		logic           left_keep;

		assign occupied[k] = count_q > CW'(k);

		if (k == 0) begin : g_head
			assign left_keep = 1'b1;
			assign left_job  = ctl.job;
		end else begin : g_body
			assign left_keep = keep[k-1];
			assign left_job  = cell_job[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign right_job = '0;
		end else begin : g_inner
			assign right_job = cell_job[k+1];
		end

		spjq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[k]),
			.left_keep (left_keep),
			.left_job  (left_job),
			.right_job (right_job),
			.keep      (keep[k]),
			.job       (cell_job[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= spjq_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) capacity_q <= cfg_data;
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_next;
			out_count_q <= cnt_next_w[spjq_pkg::COUNT_W-1:0];
			out_job_q   <= do_rem ? cell_job[0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_job_q.id;
	assign out_size  = out_job_q.size;
	assign out_owner = out_job_q.owner;
	assign out_rank  = out_job_q.rank;
	assign count     = out_count_q;

	// The stored count never exceeds the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("queue count beyond depth");

	// A refused insert reports full and leaves the count alone.
	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == spjq_pkg::FN_INSERT && full)
		|=> (status_q == spjq_pkg::ST_FULL) && $stable(count_q))
		else $error("refused insert changed the queue");

	// A remove from a non-empty queue takes exactly one job out.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == spjq_pkg::FN_REMOVE && !empty)
		|=> (count_q == $past(count_q) - 1'b1) && (status_q == spjq_pkg::ST_DONE))
		else $error("remove did not shrink the queue by one");

endmodule
`default_nettype wire

// ===== design/spjq_cell.sv =====
// One queue slot: holds a job, compares it with the incoming rank, shifts with its neighbors.
`default_nettype none
module spjq_cell (
	input  wire                 clk,
	input  spjq_pkg::cell_ctl_t ctl,
	input  wire                 occupied,
	input  wire                 left_keep,
	input  spjq_pkg::job_t      left_job,
	input  spjq_pkg::job_t      right_job,
	output logic                keep,
	output spjq_pkg::job_t      job
);

	spjq_pkg::job_t job_q;

	// A stored job stays in place when it ranks at or above the new job.
	assign keep = occupied && ($signed(job_q.rank) >= $signed(ctl.job.rank));
	assign job  = job_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			// The first slot that does not keep takes the new job; later ones shift down.
			job_q <= left_keep ? ctl.job : left_job;
		end else if (ctl.rem) begin
			job_q <= right_job;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sorted_priority_job_queue_tb.sv =====
// Self-checking testbench for the sorted job priority queue.
module sorted_priority_job_queue_tb;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]                   status;
		spjq_pkg::job_t               job;
		logic [spjq_pkg::COUNT_W-1:0] count;
	} queue_result_t;

	typedef enum logic { ROW_OP, ROW_CFG } row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic                       op;
		spjq_pkg::job_t             job;
		logic [spjq_pkg::CAP_W-1:0] cap;
		bit                         typed;
		queue_result_t              want;
	} stim_row_t;

	typedef struct {
		int cap;
		int snd_idle;
		int rcv_idle;
		int items;
		int insert_pct;
		int hold_at;
		int pause_at;
	} phase_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic        [15:0]  job_id;
	logic        [15:0]  job_size;
	logic        [7:0]   job_owner;
	logic signed [15:0]  job_rank;
	logic                out_valid;
	logic                out_ready;
	logic        [1:0]   status;
	logic        [15:0]  out_id;
	logic        [15:0]  out_size;
	logic        [7:0]   out_owner;
	logic signed [15:0]  out_rank;
	logic        [4:0]   count;
	logic                cfg_valid;
	logic                cfg_ready;
	logic        [4:0]   cfg_data;

	// Shadow copy of the queue contents and settings.
	spjq_pkg::job_t             model_jobs [QDEPTH];
	int                         model_count;
	logic [spjq_pkg::CAP_W-1:0] model_cap;

	queue_result_t       pending_results [$];
	stim_row_t           directed_rows [$];
	phase_t              phases [$];

	int                  mismatches;
	int                  cycles;
	int                  snd_idle;
	int                  rcv_idle;
	int                  hold_left;

	sorted_priority_job_queue #(
		.DEPTH(QDEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.job_id(job_id),
		.job_size(job_size),
		.job_owner(job_owner),
		.job_rank(job_rank),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_id(out_id),
		.out_size(out_size),
		.out_owner(out_owner),
		.out_rank(out_rank),
		.count(count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_priority_job_queue_tb: done, errors");
			$finish;
		end
	end

	// Inserts go behind every stored job of greater or equal rank, so ties stay in order.
	function automatic queue_result_t apply_queue_op(logic op, spjq_pkg::job_t j);
		queue_result_t r;
		int            limit;
		int            pos;
		int            k;
		r = '0;
		limit = (model_cap > QDEPTH) ? QDEPTH : int'(model_cap);
		if (op == spjq_pkg::FN_INSERT) begin
			if (model_count >= limit) begin
				r.status = spjq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < model_count && $signed(model_jobs[pos].rank) >= $signed(j.rank))
					pos++;
				for (k = model_count; k > pos; k--)
					model_jobs[k] = model_jobs[k-1];
				model_jobs[pos] = j;
				model_count++;
			end
		end else if (model_count == 0) begin
			r.status = spjq_pkg::ST_EMPTY;
		end else begin
			r.job = model_jobs[0];
			for (k = 0; k + 1 < model_count; k++)
				model_jobs[k] = model_jobs[k+1];
			model_count--;
		end
		r.status = r.status;
		r.count = spjq_pkg::COUNT_W'(model_count);
		return r;
	endfunction

	function automatic spjq_pkg::job_t mk_job(logic [15:0] id, logic [15:0] size,
			logic [7:0] owner, logic [15:0] rank);
		spjq_pkg::job_t j;
		j.id = id;
		j.size = size;
		j.owner = owner;
		j.rank = rank;
		return j;
	endfunction

	function automatic queue_result_t mk_result(logic [1:0] st, spjq_pkg::job_t j,
			logic [4:0] cnt);
		queue_result_t r;
		r.status = st;
		r.job = j;
		r.count = cnt;
		return r;
	endfunction

	function automatic logic [15:0] pick_rank();
		logic [15:0] r;
		case ($urandom_range(9))
			0, 1, 2, 3: r = 16'($urandom_range(6)) - 16'd3;
			4: r = 16'h7FFF;
			5: r = 16'h8000;
			default: r = 16'($urandom);
		endcase
		return r;
	endfunction

	task automatic add_row(logic op, spjq_pkg::job_t j, bit typed, queue_result_t want);
		stim_row_t row;
		row.kind = ROW_OP;
		row.op = op;
		row.job = j;
		row.cap = '0;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg_row(logic [spjq_pkg::CAP_W-1:0] cap);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.op = spjq_pkg::FN_INSERT;
		row.job = '0;
		row.cap = cap;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_phase(int cap, int sidle, int ridle, int n, int ins, int hold, int pause);
		phase_t p;
		p.cap = cap;
		p.snd_idle = sidle;
		p.rcv_idle = ridle;
		p.items = n;
		p.insert_pct = ins;
		p.hold_at = hold;
		p.pause_at = pause;
		phases.push_back(p);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	// Offers one beat and records what should come back once it is taken.
	task automatic send_op(logic op, spjq_pkg::job_t j, bit typed, queue_result_t want);
		queue_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		job_id <= j.id;
		job_size <= j.size;
		job_owner <= j.owner;
		job_rank <= j.rank;
		do
			@(posedge clk);
		while (!in_ready);
		r = apply_queue_op(op, j);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [spjq_pkg::CAP_W-1:0] cap);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		model_cap = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random back-pressure, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		queue_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, status %0d count %0d",
					status, count));
			end else begin
				w = pending_results.pop_front();
				if (status != w.status)
					report_mismatch($sformatf("status got %0d expected %0d", status, w.status));
				if (out_id != w.job.id)
					report_mismatch($sformatf("out_id got %h expected %h", out_id, w.job.id));
				if (out_size != w.job.size)
					report_mismatch($sformatf("out_size got %h expected %h", out_size, w.job.size));
				if (out_owner != w.job.owner)
					report_mismatch($sformatf("out_owner got %h expected %h", out_owner,
						w.job.owner));
				if (out_rank != w.job.rank)
					report_mismatch($sformatf("out_rank got %h expected %h", out_rank, w.job.rank));
				if (count != w.count)
					report_mismatch($sformatf("count got %0d expected %0d", count, w.count));
			end
		end
	end

	initial begin
		spjq_pkg::job_t j;
		logic           op;
		phase_t         p;
		int             i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = spjq_pkg::FN_INSERT;
		job_id = '0;
		job_size = '0;
		job_owner = '0;
		job_rank = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_ready = 1'b0;
		hold_left = 0;
		snd_idle = 0;
		rcv_idle = 0;
		mismatches = 0;
		cycles = 0;
		model_count = 0;
		model_cap = spjq_pkg::CAP_RESET;

		// Directed part: ordering at the rank extremes, ties, empty and full queues,
		// and capacities of zero, below the count and above the depth.
		add_row(spjq_pkg::FN_REMOVE, '0, 1, mk_result(spjq_pkg::ST_EMPTY, '0, 5'd0));
		add_row(spjq_pkg::FN_INSERT, mk_job(16'hFFFF, 16'hFFFF, 8'hFF, 16'h7FFF), 1,
			mk_result(spjq_pkg::ST_DONE, '0, 5'd1));
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0000, 16'h0000, 8'h00, 16'h8000), 1,
			mk_result(spjq_pkg::ST_DONE, '0, 5'd2));
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0001, 16'h1111, 8'h11, 16'h0000), 0, '0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0002, 16'h2222, 8'h22, 16'h0000), 0, '0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0003, 16'h3333, 8'h33, 16'h7FFF), 0, '0);
		add_row(spjq_pkg::FN_REMOVE, '0, 1,
			mk_result(spjq_pkg::ST_DONE, mk_job(16'hFFFF, 16'hFFFF, 8'hFF, 16'h7FFF), 5'd4));
		for (i = 0; i < 4; i++)
			add_row(spjq_pkg::FN_REMOVE, '0, 0, '0);
		add_row(spjq_pkg::FN_REMOVE, mk_job(16'hA5A5, 16'h5A5A, 8'hC3, 16'h1234), 1,
			mk_result(spjq_pkg::ST_EMPTY, '0, 5'd0));
		add_cfg_row(5'd0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h1234, 16'h5678, 8'h9A, 16'h0042), 1,
			mk_result(spjq_pkg::ST_FULL, '0, 5'd0));
		add_cfg_row(5'd2);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0A5A, 16'h0040, 8'h05, 16'h0005), 0, '0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0B6B, 16'h0080, 8'h06, 16'hFFFB), 0, '0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0C7C, 16'h00C0, 8'h07, 16'h7FFF), 1,
			mk_result(spjq_pkg::ST_FULL, '0, 5'd2));
		add_cfg_row(5'd1);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0D8D, 16'h0100, 8'h08, 16'h0009), 1,
			mk_result(spjq_pkg::ST_FULL, '0, 5'd2));
		add_row(spjq_pkg::FN_REMOVE, '0, 0, '0);
		add_row(spjq_pkg::FN_INSERT, mk_job(16'h0E9E, 16'h0140, 8'h09, 16'h8000), 1,
			mk_result(spjq_pkg::ST_FULL, '0, 5'd1));
		add_cfg_row(5'd31);
		add_row(spjq_pkg::FN_REMOVE, '0, 0, '0);

		add_phase(16, 28, 45, 120, 70, 60, -1);
		add_phase(5, 28, 45, 100, 50, -1, -1);
		add_phase(31, 45, 28, 120, 75, -1, 70);
		add_phase(1, 45, 28, 80, 50, -1, -1);
		add_phase(0, 0, 0, 30, 50, -1, -1);
		add_phase(16, 0, 0, 100, 65, 40, -1);
		add_phase(int'($urandom_range(31)), 0, 0, 100, 45, -1, -1);
		add_phase(int'($urandom_range(31)), 0, 0, 100, 55, -1, 50);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 28;
		rcv_idle = 45;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG)
				write_capacity(directed_rows[r].cap);
			else
				send_op(directed_rows[r].op, directed_rows[r].job, directed_rows[r].typed,
					directed_rows[r].want);
		end

		foreach (phases[n]) begin
			p = phases[n];
			write_capacity(spjq_pkg::CAP_W'(p.cap));
			@(posedge clk);
			snd_idle = p.snd_idle;
			rcv_idle = p.rcv_idle;
			for (i = 0; i < p.items; i++) begin
				// The result side stalls long enough for the input to back up behind it.
				if (i == p.hold_at)
					hold_left = 60;
				if (i == p.pause_at)
					drain();
				op = ($urandom_range(99) < p.insert_pct) ? spjq_pkg::FN_INSERT
					: spjq_pkg::FN_REMOVE;
				j = mk_job(16'($urandom), 16'($urandom), 8'($urandom), pick_rank());
				send_op(op, j, 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_priority_job_queue_tb: done, clean");
		else
			$display("sorted_priority_job_queue_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/spjq_pkg.sv
design/spjq_cell.sv
design/sorted_priority_job_queue.sv
tb/sorted_priority_job_queue_tb.sv
